/* rtl/core/rmq_pkg.sv */
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: shared definitions
// Types, stage counts and branch codes for the conversion pipeline.
// ---------------------------------------------------------------------------
package rmq_pkg;

	localparam int ELEM_W    = 32;
	localparam int PAIR_W    = 33;
	localparam int RAD_W     = 64;
	localparam int REM_W     = 35;
	localparam int SQ_STAGES = 32;
	localparam int DV_STAGES = 32;
	localparam int IN_W      = 9 * ELEM_W;
	localparam int OUT_W     = 4 * ELEM_W;
	localparam int USER_W    = 3;

	typedef logic [1:0] br_t;

	localparam br_t BR_TRACE = 2'd0;
	localparam br_t BR_X     = 2'd1;
	localparam br_t BR_Y     = 2'd2;
	localparam br_t BR_Z     = 2'd3;

	typedef struct packed {
		logic                   valid;
		br_t                    br;
		logic                   degen;
		logic [2:0][PAIR_W-1:0] pair;
		logic [RAD_W-1:0]       rad;
		logic [REM_W-1:0]       rem;
		logic [ELEM_W-1:0]      root;
	} sq_t;

	typedef struct packed {
		logic                   valid;
		br_t                    br;
		logic                   degen;
		logic [ELEM_W-1:0]      diag;
		logic [ELEM_W-1:0]      den;
		logic [2:0]             neg;
		logic [2:0]             ovf;
		logic [2:0][ELEM_W-1:0] num;
		logic [2:0][ELEM_W-1:0] rem;
		logic [2:0][ELEM_W-1:0] quo;
	} dv_t;

endpackage

/* rtl/core/rotation_matrix_to_quaternion_unit.sv */
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion unit
// Trace-branching conversion of a Q2.30 rotation matrix into a saturated
// Q2.30 quaternion, with a bit-per-stage square root and three dividers.
// ---------------------------------------------------------------------------
// From input accept to output valid the pipeline runs through one stage for the
// branch choice, 32 square root stages, one divider set-up stage, 32 divider
// stages and the output register. Throughput is one item per cycle; the whole
// pipeline holds while a result waits unaccepted. The asynchronous reset
// clears every pipeline register; the output data register is not reset.
module rotation_matrix_to_quaternion_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, 32 bits each
	input  logic [rmq_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// quat_w, quat_x, quat_y, quat_z from bit 0 up, 32 bits each
	output logic [rmq_pkg::OUT_W-1:0] m_tdata,
	// branch_taken in bits 1:0, degenerate in bit 2
	output logic [rmq_pkg::USER_W-1:0] m_tuser
);
	import rmq_pkg::*;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---- stage 1: branch choice, radicand and pairs ----
	logic signed [ELEM_W-1:0] m [9];
	logic signed [34:0] tr, r0, r1, r2, r3, r_sel;
	logic signed [PAIR_W-1:0] p_21m12, p_02m20, p_10m01, p_01p10, p_02p20, p_12p21;
	br_t br_c;
	logic [2:0][PAIR_W-1:0] pair_c;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			m[i] = s_tdata[i*ELEM_W +: ELEM_W];
		end
		tr = 35'(m[0]) + 35'(m[4]) + 35'(m[8]);
		r0 = tr + 35'sd1073741824;
		r1 = 35'sd1073741824 + 35'(m[0]) - 35'(m[4]) - 35'(m[8]);
		r2 = 35'sd1073741824 + 35'(m[4]) - 35'(m[0]) - 35'(m[8]);
		r3 = 35'sd1073741824 + 35'(m[8]) - 35'(m[0]) - 35'(m[4]);
		p_21m12 = PAIR_W'(m[7]) - PAIR_W'(m[5]);
		p_02m20 = PAIR_W'(m[2]) - PAIR_W'(m[6]);
		p_10m01 = PAIR_W'(m[3]) - PAIR_W'(m[1]);
		p_01p10 = PAIR_W'(m[1]) + PAIR_W'(m[3]);
		p_02p20 = PAIR_W'(m[2]) + PAIR_W'(m[6]);
		p_12p21 = PAIR_W'(m[5]) + PAIR_W'(m[7]);
		priority if (tr > 35'sd0) begin
			br_c = BR_TRACE;
		end else if (m[0] > m[4] && m[0] > m[8]) begin
			br_c = BR_X;
		end else if (m[4] > m[8]) begin
			br_c = BR_Y;
		end else begin
			br_c = BR_Z;
		end
		unique case (br_c)
			BR_TRACE: begin
				r_sel  = r0;
				pair_c = {p_10m01, p_02m20, p_21m12};
			end
			BR_X: begin
				r_sel  = r1;
				pair_c = {p_02p20, p_01p10, p_21m12};
			end
			BR_Y: begin
				r_sel  = r2;
				pair_c = {p_12p21, p_01p10, p_02m20};
			end
			default: begin
				r_sel  = r3;
				pair_c = {p_12p21, p_02p20, p_10m01};
			end
		endcase
	end

	sq_t s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1 <= '0;
		end else if (en) begin
			s1.valid <= s_tvalid;
			s1.br    <= br_c;
			s1.degen <= (r_sel <= 35'sd0);
			s1.pair  <= pair_c;
			// The radicand stays below 2^33, so it is shifted up to 2^30 scale.
			s1.rad   <= (r_sel <= 35'sd0) ? '0 : {1'b0, r_sel[32:0], 30'd0};
			s1.rem   <= '0;
			s1.root  <= '0;
		end
	end

	// ---- stage group 2: square root, one root bit per stage ----
	sq_t sq_s2   [SQ_STAGES];
	sq_t sq_nx   [SQ_STAGES];

	always_comb begin
		sq_t               pv;
		logic [REM_W-1:0]  cur;
		logic [REM_W-1:0]  trial;
		for (int k = 0; k < SQ_STAGES; k++) begin
			pv    = (k == 0) ? s1 : sq_s2[k-1];
			cur   = {pv.rem[REM_W-3:0], pv.rad[RAD_W-1:RAD_W-2]};
			trial = {1'b0, pv.root, 2'b01};
			sq_nx[k]     = pv;
			sq_nx[k].rad = {pv.rad[RAD_W-3:0], 2'b00};
			if (cur >= trial) begin
				sq_nx[k].rem  = cur - trial;
				sq_nx[k].root = {pv.root[ELEM_W-2:0], 1'b1};
			end else begin
				sq_nx[k].rem  = cur;
				sq_nx[k].root = {pv.root[ELEM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SQ_STAGES; k++) begin
				sq_s2[k] <= '0;
			end
		end else if (en) begin
			for (int k = 0; k < SQ_STAGES; k++) begin
				sq_s2[k] <= sq_nx[k];
			end
		end
	end

	// ---- stage 3: divider set-up ----
	// The half root equals the root shifted down by one, so one root serves both.
	dv_t pr_nx, pr_s3;

	always_comb begin
		sq_t                      lst;
		logic signed [PAIR_W-1:0] p;
		logic [PAIR_W-1:0]        mag;
		lst = sq_s2[SQ_STAGES-1];
		pr_nx.valid = lst.valid;
		pr_nx.br    = lst.br;
		pr_nx.degen = lst.degen;
		pr_nx.den   = lst.root;
		pr_nx.diag  = {1'b0, lst.root[ELEM_W-1:1]};
		for (int l = 0; l < 3; l++) begin
			p   = lst.pair[l];
			mag = p[PAIR_W-1] ? PAIR_W'(-p) : PAIR_W'(p);
			pr_nx.neg[l] = p[PAIR_W-1];
			// A quotient of 2^32 or more saturates whatever the sign.
			pr_nx.ovf[l] = {2'b00, mag} >= {lst.root, 3'b000};
			pr_nx.rem[l] = {2'b00, mag[PAIR_W-1:3]};
			pr_nx.num[l] = {mag[2:0], 29'd0};
			pr_nx.quo[l] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_s3 <= '0;
		end else if (en) begin
			pr_s3 <= pr_nx;
		end
	end

	// ---- stage group 4: three restoring dividers, one quotient bit per stage ----
	dv_t dv_s4 [DV_STAGES];
	dv_t dv_nx [DV_STAGES];

	always_comb begin
		dv_t               pv;
		logic [ELEM_W:0]   cur;
		for (int k = 0; k < DV_STAGES; k++) begin
			pv = (k == 0) ? pr_s3 : dv_s4[k-1];
			dv_nx[k] = pv;
			for (int l = 0; l < 3; l++) begin
				cur = {pv.rem[l], pv.num[l][ELEM_W-1]};
				dv_nx[k].num[l] = {pv.num[l][ELEM_W-2:0], 1'b0};
				if (cur >= {1'b0, pv.den}) begin
					dv_nx[k].rem[l] = ELEM_W'(cur - {1'b0, pv.den});
					dv_nx[k].quo[l] = {pv.quo[l][ELEM_W-2:0], 1'b1};
				end else begin
					dv_nx[k].rem[l] = cur[ELEM_W-1:0];
					dv_nx[k].quo[l] = {pv.quo[l][ELEM_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DV_STAGES; k++) begin
				dv_s4[k] <= '0;
			end
		end else if (en) begin
			for (int k = 0; k < DV_STAGES; k++) begin
				dv_s4[k] <= dv_nx[k];
			end
		end
	end

	// ---- output: saturation and placement ----
	logic [2:0][ELEM_W-1:0] sat_c;
	logic [OUT_W-1:0]       quat_c;

	always_comb begin
		dv_t lst;
		lst = dv_s4[DV_STAGES-1];
		for (int l = 0; l < 3; l++) begin
			if (lst.neg[l]) begin
				sat_c[l] = (lst.ovf[l] || lst.quo[l] > 32'h8000_0000) ?
					32'h8000_0000 : -lst.quo[l];
			end else begin
				sat_c[l] = (lst.ovf[l] || lst.quo[l][ELEM_W-1]) ?
					32'h7FFF_FFFF : lst.quo[l];
			end
		end
		unique case (lst.br)
			BR_TRACE: quat_c = {sat_c[2], sat_c[1], sat_c[0], lst.diag};
			BR_X:     quat_c = {sat_c[2], sat_c[1], lst.diag, sat_c[0]};
			BR_Y:     quat_c = {sat_c[2], lst.diag, sat_c[1], sat_c[0]};
			default:  quat_c = {lst.diag, sat_c[2], sat_c[1], sat_c[0]};
		endcase
		if (lst.degen) begin
			quat_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dv_s4[DV_STAGES-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= quat_c;
			m_tuser <= {dv_s4[DV_STAGES-1].degen, dv_s4[DV_STAGES-1].br};
		end
	end

	// ---- assertions ----
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tdata == '0)
		else $error("degenerate result carries a non-zero quaternion");

	a_trace_not_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == BR_TRACE |-> !m_tuser[2])
		else $error("trace branch reported as degenerate");

	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		pr_s3.valid && !pr_s3.degen |-> pr_s3.den >= 32'd32768)
		else $error("square root below the least possible root");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(dv_s4[DV_STAGES-1].valid) && $stable(s1.valid))
		else $error("pipeline moved while the output was stalled");

endmodule

/* tb/rotation_matrix_to_quaternion_unit_checker.sv */
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion checker
// Watches both streams of the unit, works out the quaternion, branch and
// degenerate flag of every accepted matrix, and compares them in order with
// the results that come out.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [rmq_pkg::IN_W-1:0]    s_tdata,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [rmq_pkg::OUT_W-1:0]   m_tdata,
	input  logic [rmq_pkg::USER_W-1:0]  m_tuser,
	output int                          failures,
	output int                          pending,
	output int                          results_seen,
	output int                          degen_seen,
	output int                          branch_seen [4]
);
	import rmq_pkg::*;

	typedef struct packed {
		logic [31:0] w, x, y, z;
		br_t         br;
		logic        degen;
	} quat_res_t;

	quat_res_t expected_quats[$];

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sh7FFF_FFFF)
			return 32'h7FFF_FFFF;
		if (v < -64'sh8000_0000)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	// Scales the pair by 2^29 and divides, truncating towards zero.
	function automatic logic [31:0] pair_quot(longint p, longint unsigned den);
		longint unsigned mag, quo;
		mag = (p < 0) ? longint'(-p) : longint'(p);
		quo = (mag << 29) / den;
		if (p < 0)
			return (quo > 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(quo));
		return (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
	endfunction

	function automatic quat_res_t convert_matrix(logic [IN_W-1:0] d);
		longint e [9];
		longint tr, rad, pa, pb, pc;
		logic [31:0] comp [4];
		logic [31:0] rest [3];
		longint unsigned den;
		quat_res_t res;
		int j;
		for (int k = 0; k < 9; k++)
			e[k] = longint'(signed'(d[k*32 +: 32]));
		tr = e[0] + e[4] + e[8];
		if (tr > 0) begin
			res.br = BR_TRACE;
			rad = tr + (64'sd1 << 30);
			pa = e[7] - e[5]; pb = e[2] - e[6]; pc = e[3] - e[1];
		end else if (e[0] > e[4] && e[0] > e[8]) begin
			res.br = BR_X;
			rad = (64'sd1 << 30) + e[0] - e[4] - e[8];
			pa = e[7] - e[5]; pb = e[1] + e[3]; pc = e[2] + e[6];
		end else if (e[4] > e[8]) begin
			res.br = BR_Y;
			rad = (64'sd1 << 30) + e[4] - e[0] - e[8];
			pa = e[2] - e[6]; pb = e[1] + e[3]; pc = e[5] + e[7];
		end else begin
			res.br = BR_Z;
			rad = (64'sd1 << 30) + e[8] - e[0] - e[4];
			pa = e[3] - e[1]; pb = e[2] + e[6]; pc = e[5] + e[7];
		end
		res.degen = (rad <= 0);
		for (int k = 0; k < 4; k++)
			comp[k] = '0;
		if (!res.degen) begin
			den = int_sqrt(longint'(rad) << 30);
			rest[0] = pair_quot(pa, den);
			rest[1] = pair_quot(pb, den);
			rest[2] = pair_quot(pc, den);
			j = 0;
			for (int k = 0; k < 4; k++) begin
				if (k == int'(res.br)) begin
					comp[k] = clamp32(longint'(int_sqrt(longint'(rad) << 28)));
				end else begin
					comp[k] = rest[j];
					j++;
				end
			end
		end
		res.w = comp[0]; res.x = comp[1]; res.y = comp[2]; res.z = comp[3];
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on result %0d: %s got %h expected %h", results_seen, what, got, want);
		failures++;
	endtask

	initial begin
		failures = 0;
		pending = 0;
		results_seen = 0;
		degen_seen = 0;
		for (int k = 0; k < 4; k++)
			branch_seen[k] = 0;
	end

	always @(posedge clk) begin
		quat_res_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_quats.insert(expected_quats.size(), convert_matrix(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_quats.size() == 0) begin
					$display("result %0d arrived with no matrix outstanding", results_seen);
					failures++;
				end else begin
					want = expected_quats.pop_front();
					if (m_tdata[31:0] !== want.w)
						report_mismatch("quat_w", m_tdata[31:0], want.w);
					if (m_tdata[63:32] !== want.x)
						report_mismatch("quat_x", m_tdata[63:32], want.x);
					if (m_tdata[95:64] !== want.y)
						report_mismatch("quat_y", m_tdata[95:64], want.y);
					if (m_tdata[127:96] !== want.z)
						report_mismatch("quat_z", m_tdata[127:96], want.z);
					if (m_tuser[1:0] !== want.br)
						report_mismatch("branch_taken", 32'(m_tuser[1:0]), 32'(want.br));
					if (m_tuser[2] !== want.degen)
						report_mismatch("degenerate", 32'(m_tuser[2]), 32'(want.degen));
					branch_seen[want.br]++;
					if (want.degen)
						degen_seen++;
				end
				results_seen++;
			end
		end
		pending = expected_quats.size();
	end

endmodule

/* tb/rotation_matrix_to_quaternion_unit_tb.sv */
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion unit testbench
// Feeds directed and random matrices (proper rotations, noisy and raw
// patterns) in bursts against a stalling receiver; the checker compares.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_tb;
	import rmq_pkg::*;

	localparam int ONE        = 32'sh4000_0000;
	localparam int N_RANDOM   = 1100;
	localparam int LATENCY    = 67;
	localparam int CYCLE_LIMIT = 400000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic [USER_W-1:0]    m_tuser;

	int failures, pending, results_seen, degen_seen;
	int branch_seen [4];
	int cycles;
	int items_sent;
	int stall_mode;

	rotation_matrix_to_quaternion_unit DUT (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser
	);

	rotation_matrix_to_quaternion_unit_checker checker_i (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.failures, .pending, .results_seen, .degen_seen, .branch_seen
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("rotation_matrix_to_quaternion_unit_tb NOT OK");
				$finish;
			end
		end
	end

	// The receiver switches between always ready, light and heavy stalling.
	initial begin
		m_tready = 1'b0;
		stall_mode = 0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	function automatic logic [IN_W-1:0] pack_rows(int e [9]);
		logic [IN_W-1:0] d;
		for (int k = 0; k < 9; k++)
			d[k*32 +: 32] = e[k];
		return d;
	endfunction

	// Multiplies two Q2.30 values, truncating.
	function automatic int qmul(int a, int b);
		longint p;
		p = longint'(a) * longint'(b);
		return int'(p >>> 30);
	endfunction

	// A proper rotation built from a random unit quaternion, so every branch
	// is reached with nearly orthonormal matrices.
	function automatic logic [IN_W-1:0] rand_rotation();
		int q [4];
		int e [9];
		int w, x, y, z;
		longint n2;
		real nr;
		do begin
			n2 = 0;
			for (int k = 0; k < 4; k++) begin
				q[k] = $urandom_range(0, 2 * ONE) - ONE;
				n2 += longint'(q[k]) * q[k];
			end
		end while (n2 < (64'sd1 << 56));
		nr = $sqrt(real'(n2)) / real'(ONE);
		w = int'(q[0] / nr); x = int'(q[1] / nr);
		y = int'(q[2] / nr); z = int'(q[3] / nr);
		e[0] = ONE - 2 * (qmul(y, y) + qmul(z, z));
		e[1] = 2 * (qmul(x, y) - qmul(z, w));
		e[2] = 2 * (qmul(x, z) + qmul(y, w));
		e[3] = 2 * (qmul(x, y) + qmul(z, w));
		e[4] = ONE - 2 * (qmul(x, x) + qmul(z, z));
		e[5] = 2 * (qmul(y, z) - qmul(x, w));
		e[6] = 2 * (qmul(x, z) - qmul(y, w));
		e[7] = 2 * (qmul(y, z) + qmul(x, w));
		e[8] = ONE - 2 * (qmul(x, x) + qmul(y, y));
		return pack_rows(e);
	endfunction

	function automatic logic [IN_W-1:0] rand_bits();
		logic [IN_W-1:0] d;
		for (int k = 0; k < 9; k++)
			d[k*32 +: 32] = $urandom();
		return d;
	endfunction

	function automatic logic [IN_W-1:0] diag_matrix(int a, int b, int c, int off);
		int e [9];
		e = '{a, off, -off, -off, b, off, off, -off, c};
		return pack_rows(e);
	endfunction

	task automatic send_matrix(logic [IN_W-1:0] d);
		s_tdata  <= d;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
	endtask

	task automatic idle_gap();
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 12))
			@(posedge clk);
	endtask

	logic [IN_W-1:0] directed [$];
	logic [IN_W-1:0] d;
	int burst_left;
	int sel;

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		items_sent = 0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity, half-turns about each axis, ties on the diagonal, negative
		// and zero radicands, extreme elements and saturating pairs.
		directed.insert(directed.size(), diag_matrix(ONE, ONE, ONE, 0));
		directed.insert(directed.size(), diag_matrix(ONE, -ONE, -ONE, 0));
		directed.insert(directed.size(), diag_matrix(-ONE, ONE, -ONE, 0));
		directed.insert(directed.size(), diag_matrix(-ONE, -ONE, ONE, 0));
		directed.insert(directed.size(), diag_matrix(0, 0, 0, 0));
		directed.insert(directed.size(), diag_matrix(-ONE, -ONE, -ONE, 0));
		directed.insert(directed.size(), diag_matrix(-ONE / 2, -ONE / 2, 0, 0));
		directed.insert(directed.size(), diag_matrix(-ONE, 0, 0, 0));
		directed.insert(directed.size(), diag_matrix(0, 0, -ONE, 0));
		directed.insert(directed.size(), diag_matrix(32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 0));
		directed.insert(directed.size(), diag_matrix(32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		directed.insert(directed.size(), diag_matrix(32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000));
		directed.insert(directed.size(), diag_matrix(32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000, 32'sh7FFF_FFFF));
		directed.insert(directed.size(), diag_matrix(-ONE + 1, -ONE, -ONE, 32'sh7FFF_FFFF));
		directed.insert(directed.size(), diag_matrix(1, 0, 0, 32'sh8000_0000));
		directed.insert(directed.size(), diag_matrix(-2, 1, 0, 1));
		directed.insert(directed.size(), {IN_W{1'b1}});
		directed.insert(directed.size(), {IN_W{1'b0}});
		directed.insert(directed.size(), {9{32'hAAAA_AAAA}});
		directed.insert(directed.size(), {9{32'h5555_5555}});
		foreach (directed[k]) begin
			send_matrix(directed[k]);
			if ($urandom_range(0, 2) == 0)
				idle_gap();
		end

		// Hold off until the pipeline has drained completely once.
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);

		burst_left = 0;
		for (int n = 0; n < N_RANDOM; n++) begin
			sel = $urandom_range(0, 9);
			if (sel < 6)
				d = rand_rotation();
			else if (sel < 8)
				d = rand_rotation() ^ (rand_bits() & {9{32'h0000_FFFF}});
			else
				d = rand_bits();
			if (burst_left == 0) begin
				if (n != 0 && $urandom_range(0, 1) == 0)
					idle_gap();
				burst_left = $urandom_range(1, 40);
			end
			send_matrix(d);
			burst_left--;
		end
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 10)
			@(posedge clk);

		$display("%0d matrices sent, %0d results checked, %0d degenerate", items_sent,
			results_seen, degen_seen);
		$display("branches seen: trace %0d, x %0d, y %0d, z %0d", branch_seen[0],
			branch_seen[1], branch_seen[2], branch_seen[3]);
		if (failures == 0 && pending == 0)
			$display("rotation_matrix_to_quaternion_unit_tb OK");
		else
			$display("rotation_matrix_to_quaternion_unit_tb NOT OK");
		$finish;
	end

endmodule
